[rtl/pmsu_pkg.sv]
// Shared types and constants for the Potts lattice site-update block.
// Depends on nothing; every rtl file refers to it by scoped names.
package pmsu_pkg;

  localparam int unsigned SIDE       = 128;
  localparam int unsigned STATE_BITS = 3;
  localparam int unsigned COORD_W    = $clog2(SIDE);
  localparam int unsigned ADDR_W     = 2 * COORD_W;
  localparam int unsigned DEPTH      = SIDE * SIDE;
  localparam int unsigned PROB_W     = 16;
  localparam int unsigned NUM_PROB   = 4;
  localparam int unsigned PROB_SEL_W = $clog2(NUM_PROB);
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned COUNT_W    = 3;

  typedef logic [STATE_BITS-1:0] spin_t;
  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [PROB_W-1:0]     prob_t;
  typedef logic [COUNT_W-1:0]    count_t;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_TRIAL = 2'd1,
    OP_READ  = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTER,
    ST_NORTH,
    ST_SOUTH,
    ST_WEST,
    ST_EAST
  } state_e;

  // One access to the lattice memory per cycle.
  typedef struct packed {
    logic  we;
    logic  re;
    addr_t addr;
    spin_t wdata;
  } ram_req_t;

  // Number of neighbors equal to val.
  function automatic count_t match_count(spin_t val, spin_t a, spin_t b, spin_t c, spin_t d);
    count_t n;
    n = count_t'(a == val) + count_t'(b == val) + count_t'(c == val) + count_t'(d == val);
    return n;
  endfunction

endpackage

[rtl/pmsu_lattice_ram.sv]
// Single-port lattice memory with a registered read port.
// Depends on pmsu_pkg for the request struct and sizes.
module pmsu_lattice_ram (
  input  logic               clk_i,
  input  pmsu_pkg::ram_req_t req_i,
  output pmsu_pkg::spin_t    rdata_o
);

  pmsu_pkg::spin_t mem [pmsu_pkg::DEPTH];
  pmsu_pkg::spin_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/potts_metropolis_site_update_top.sv]
// Potts-model Metropolis site update over a 128 x 128 wrapped lattice.
// Depends on pmsu_pkg and pmsu_lattice_ram.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per item:
//   opcode, row, col, trial_state, random_roll. A beat is taken when valid
//   is high and stall is low. Output channel (out_valid_o / out_stall_i)
//   returns exactly one beat per item: site_value and accepted.
//   Configuration (cfg_valid_i / cfg_ready_o) writes the four acceptance
//   thresholds by index 0..3; other indexes are dropped. cfg_ready_o is
//   always high. Write thresholds only while the block is idle.
// Timing:
//   All lattice accesses share the single port of one memory, so the item
//   rate follows the number of accesses: a site write is one access, a read
//   is one access followed by loading the result, and a trial is five reads,
//   then decision and write-back, before the result shows on the output register.
//   A new item is taken only once the previous one is through and the sequencer is idle.
// Reset: clears the sequencer, the output valid flag and the thresholds.
//   Lattice contents are undefined until loaded with site writes.
// Back-pressure: a result waits in the output register while the receiver
//   stalls; a new item is held off while that register is stalled or the sequencer is busy.
module potts_metropolis_site_update_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input beats
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [pmsu_pkg::OP_W-1:0]       opcode_i,
  input  pmsu_pkg::coord_t               row_i,
  input  pmsu_pkg::coord_t               col_i,
  input  pmsu_pkg::spin_t                trial_state_i,
  input  pmsu_pkg::prob_t                random_roll_i,
  // result beats
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pmsu_pkg::spin_t                site_value_o,
  output logic                           accepted_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pmsu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  pmsu_pkg::prob_t                cfg_data_i
);

  pmsu_pkg::state_e   state_q, state_d;
  pmsu_pkg::ram_req_t ram_req;
  pmsu_pkg::spin_t    ram_rdata;

  // Latched item.
  pmsu_pkg::coord_t   row_q, col_q;
  pmsu_pkg::spin_t    trial_q;
  pmsu_pkg::prob_t    roll_q;
  logic               is_trial_q;

  // Gathered neighborhood; the east neighbor is used straight from the memory.
  pmsu_pkg::spin_t    cur_q, n0_q, n1_q, n2_q;

  // Output register.
  logic               out_valid_q;
  pmsu_pkg::spin_t    site_q, site_d;
  logic               acc_q, acc_d;
  logic               load_out;

  pmsu_pkg::prob_t    prob_q [pmsu_pkg::NUM_PROB];

  logic               in_fire;
  pmsu_pkg::count_t   cur_count, trial_count, rise;
  pmsu_pkg::count_t   rise_m1;
  logic               trial_ok;

  assign in_stall_o  = (state_q != pmsu_pkg::ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Energy comparison once all four neighbors are in.
  always_comb begin
    cur_count   = pmsu_pkg::match_count(cur_q, n0_q, n1_q, n2_q, ram_rdata);
    trial_count = pmsu_pkg::match_count(trial_q, n0_q, n1_q, n2_q, ram_rdata);
    rise        = cur_count - trial_count;
    rise_m1     = rise - pmsu_pkg::count_t'(1);
    trial_ok    = (trial_count >= cur_count) ||
                  (roll_q < prob_q[rise_m1[pmsu_pkg::PROB_SEL_W-1:0]]);
  end

  // Sequencer: at most one memory access per cycle.
  always_comb begin
    state_d        = state_q;
    ram_req        = '0;
    load_out       = 1'b0;
    site_d         = site_q;
    acc_d          = acc_q;
    unique case (state_q)
      pmsu_pkg::ST_IDLE: begin
        if (in_fire) begin
          ram_req.addr = {row_i, col_i};
          if (pmsu_pkg::opcode_e'(opcode_i) == pmsu_pkg::OP_WRITE) begin
            ram_req.we    = 1'b1;
            ram_req.wdata = trial_state_i;
            load_out      = 1'b1;
            site_d        = trial_state_i;
            acc_d         = 1'b1;
          end else begin
            ram_req.re = 1'b1;
            state_d    = pmsu_pkg::ST_CENTER;
          end
        end
      end
      pmsu_pkg::ST_CENTER: begin
        if (is_trial_q) begin
          ram_req.re   = 1'b1;
          ram_req.addr = {pmsu_pkg::coord_t'(row_q - pmsu_pkg::coord_t'(1)), col_q};
          state_d      = pmsu_pkg::ST_NORTH;
        end else begin
          // Plain read (and the unused opcode): report the stored value.
          load_out = 1'b1;
          site_d   = ram_rdata;
          acc_d    = 1'b0;
          state_d  = pmsu_pkg::ST_IDLE;
        end
      end
      pmsu_pkg::ST_NORTH: begin
        ram_req.re   = 1'b1;
        ram_req.addr = {pmsu_pkg::coord_t'(row_q + pmsu_pkg::coord_t'(1)), col_q};
        state_d      = pmsu_pkg::ST_SOUTH;
      end
      pmsu_pkg::ST_SOUTH: begin
        ram_req.re   = 1'b1;
        ram_req.addr = {row_q, pmsu_pkg::coord_t'(col_q - pmsu_pkg::coord_t'(1))};
        state_d      = pmsu_pkg::ST_WEST;
      end
      pmsu_pkg::ST_WEST: begin
        ram_req.re   = 1'b1;
        ram_req.addr = {row_q, pmsu_pkg::coord_t'(col_q + pmsu_pkg::coord_t'(1))};
        state_d      = pmsu_pkg::ST_EAST;
      end
      pmsu_pkg::ST_EAST: begin
        // Decide and write back the trial value on acceptance.
        ram_req.we    = trial_ok;
        ram_req.addr  = {row_q, col_q};
        ram_req.wdata = trial_q;
        load_out      = 1'b1;
        site_d        = trial_ok ? trial_q : cur_q;
        acc_d         = trial_ok;
        state_d       = pmsu_pkg::ST_IDLE;
      end
      default: begin
        state_d = pmsu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pmsu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the item and the neighbors as they arrive.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      row_q      <= row_i;
      col_q      <= col_i;
      trial_q    <= trial_state_i;
      roll_q     <= random_roll_i;
      is_trial_q <= (pmsu_pkg::opcode_e'(opcode_i) == pmsu_pkg::OP_TRIAL);
    end
    if (state_q == pmsu_pkg::ST_CENTER) cur_q <= ram_rdata;
    if (state_q == pmsu_pkg::ST_NORTH)  n0_q  <= ram_rdata;
    if (state_q == pmsu_pkg::ST_SOUTH)  n1_q  <= ram_rdata;
    if (state_q == pmsu_pkg::ST_WEST)   n2_q  <= ram_rdata;
  end

  // Output register: load a finished result, drop it once the beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    site_q <= site_d;
    acc_q  <= acc_d;
  end

  // Threshold registers; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pmsu_pkg::NUM_PROB; i++) begin
        prob_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o &&
                 (cfg_index_i < pmsu_pkg::CFG_IDX_W'(pmsu_pkg::NUM_PROB))) begin
      prob_q[cfg_index_i[pmsu_pkg::PROB_SEL_W-1:0]] <= cfg_data_i;
    end
  end

  pmsu_lattice_ram u_lattice (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign site_value_o = site_q;
  assign accepted_o   = acc_q;

endmodule
